// ----- src/i2cbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
`default_nettype none

package i2cbe_pkg;

  // Command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;
  localparam logic [2:0] CMD_NACK  = 3'd5;
  localparam logic [2:0] CMD_WAIT  = 3'd6;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam logic [4:0] WRITE_LAST_SLOT = 5'(BITS_PER_BYTE * 3 - 1);
  localparam logic [4:0] READ_LAST_SLOT  = 5'(BITS_PER_BYTE * 3);
  localparam logic [4:0] SLOT_MAX        = 5'd31;
  localparam logic [7:0] TIMEOUT_RESET   = 8'd255;

  // One tick offered on the input side
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  // One tick after classification by the front end
  typedef struct packed {
    logic       start_ok;
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       sda_in;
  } cls_item_t;

  // One result per tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/i2cbe_fifo.sv -----
// Small register-based FIFO used for the tick queue and the result queue.
`default_nettype none

module i2cbe_fifo #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2cbe_front.sv -----
// Front end: accepts ticks, classifies the offered command and queues the request.
`default_nettype none

module i2cbe_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire i2cbe_pkg::in_item_t  in_item,
  output logic                      full,
  input  wire logic                 iq_pop,
  output i2cbe_pkg::cls_item_t      iq_item,
  output logic                      iq_empty
);

  import i2cbe_pkg::*;

  cls_item_t                  cls;
  logic [$bits(cls_item_t)-1:0] rd_vec;

  // Flag requests that carry a meaningful command
  always_comb begin
    cls.start_ok   = in_item.cmd_valid && (in_item.kind <= CMD_WAIT);
    cls.kind       = in_item.kind;
    cls.write_data = in_item.write_data;
    cls.sda_in     = in_item.sda_in;
  end

  i2cbe_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (DEPTH)
  ) u_iq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (cls),
    .full    (full),
    .pop     (iq_pop),
    .rd_data (rd_vec),
    .empty   (iq_empty)
  );

  assign iq_item = cls_item_t'(rd_vec);

endmodule

`default_nettype wire

// ----- src/i2cbe_back.sv -----
// Back end: bit sequencer that drives SCL/SDA one slot per queued tick.
`default_nettype none

module i2cbe_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  input  wire i2cbe_pkg::cls_item_t iq_item,
  input  wire logic                 iq_empty,
  output logic                      iq_pop,
  input  wire logic                 oq_full,
  output logic                      oq_push,
  output i2cbe_pkg::out_item_t      oq_item
);

  import i2cbe_pkg::*;

  localparam logic [1:0] PH_LOW    = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_HIGH   = 2'd2;

  logic       running_r, running_nxt;
  logic [2:0] active_r, active_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] rhold_r, rhold_nxt;
  logic       tmo_r, tmo_nxt;
  logic [7:0] limit_r;

  logic       take, run, fin, low_after;
  logic [2:0] cmd;
  logic [4:0] s;
  logic [1:0] ph, ph_adv;
  logic [7:0] sh, poll;
  logic       scl_v, sda_v;

  // Consume a request whenever the result queue has room
  assign iq_pop  = !iq_empty && !oq_full;
  assign oq_push = iq_pop;

  // Sequence one slot
  always_comb begin
    take = !running_r && iq_item.start_ok;
    run  = running_r || take;
    cmd  = take ? iq_item.kind : active_r;
    s    = take ? 5'd0 : step_r;
    ph   = take ? PH_LOW : phase_r;
    poll = take ? 8'd0 : poll_r;
    if (take) begin
      sh = (iq_item.kind == CMD_WRITE) ? iq_item.write_data : 8'd0;
    end else begin
      sh = shift_r;
    end
    ph_adv = (ph == PH_HIGH) ? PH_LOW : ph + 2'd1;

    scl_v      = scl_r;
    sda_v      = sda_r;
    fin        = 1'b0;
    low_after  = 1'b0;
    shift_nxt  = sh;
    poll_nxt   = poll;
    phase_nxt  = ph;
    rhold_nxt  = rhold_r;
    tmo_nxt    = tmo_r;

    if (run) begin
      case (cmd)
        CMD_START: begin
          if (s == 5'd0) begin
            sda_v = 1'b1;
            scl_v = 1'b1;
          end else if (s == 5'd1) begin
            sda_v = 1'b0;
          end else begin
            scl_v = 1'b0;
            fin   = 1'b1;
          end
        end
        CMD_STOP: begin
          if (s == 5'd0) begin
            scl_v = 1'b0;
            sda_v = 1'b0;
          end else if (s == 5'd1) begin
            scl_v = 1'b1;
          end else begin
            sda_v = 1'b1;
            fin   = 1'b1;
          end
        end
        CMD_ACK, CMD_NACK: begin
          if (s == 5'd0) begin
            scl_v = 1'b0;
            sda_v = (cmd == CMD_NACK);
          end else if (s == 5'd1) begin
            scl_v = 1'b1;
          end else begin
            scl_v = 1'b0;
            sda_v = 1'b1;
            fin   = 1'b1;
          end
        end
        CMD_WRITE: begin
          case (ph)
            PH_LOW:  scl_v = 1'b0;
            PH_DATA: begin
              sda_v     = sh[7];
              shift_nxt = {sh[6:0], 1'b0};
            end
            default: scl_v = 1'b1;
          endcase
          phase_nxt = ph_adv;
          if (s >= WRITE_LAST_SLOT) begin
            fin       = 1'b1;
            low_after = 1'b1;
          end
        end
        CMD_READ: begin
          if (s == 5'd0) begin
            sda_v = 1'b1;
          end else begin
            case (ph)
              PH_LOW:  scl_v = 1'b0;
              PH_DATA: scl_v = 1'b1;
              default: shift_nxt = {sh[6:0], iq_item.sda_in};
            endcase
            phase_nxt = ph_adv;
            if (s >= READ_LAST_SLOT) begin
              fin       = 1'b1;
              low_after = 1'b1;
              rhold_nxt = shift_nxt;
            end
          end
        end
        default: begin
          // wait for acknowledge: poll SDA with SCL high
          if (s == 5'd0) begin
            scl_v = 1'b0;
            sda_v = 1'b1;
          end else if (s == 5'd1) begin
            scl_v = 1'b1;
          end else if (iq_item.sda_in && (poll < limit_r)) begin
            poll_nxt = poll + 8'd1;
          end else begin
            scl_v   = 1'b0;
            fin     = 1'b1;
            tmo_nxt = (poll >= limit_r);
          end
        end
      endcase
    end

    // Advance the slot counter; the poll loop holds its slot
    if (!fin && (s < SLOT_MAX) && !((cmd == CMD_WAIT) && (s >= 5'd2))) begin
      step_nxt = s + 5'd1;
    end else begin
      step_nxt = s;
    end
    running_nxt = run && !fin;
    active_nxt  = cmd;
    sda_nxt     = sda_v;
    scl_nxt     = scl_v;
    if (fin) begin
      step_nxt = 5'd0;
      if (low_after) begin
        scl_nxt = 1'b0;
      end
    end

    oq_item.scl_out   = scl_v;
    oq_item.sda_out   = sda_v;
    oq_item.busy_res  = run;
    oq_item.done_res  = fin;
    oq_item.read_data = rhold_nxt;
    oq_item.no_ack    = tmo_nxt;
  end

  // Hold sequencer state between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      active_r  <= CMD_START;
      step_r    <= 5'd0;
      phase_r   <= PH_LOW;
      shift_r   <= 8'd0;
      poll_r    <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rhold_r   <= 8'd0;
      tmo_r     <= 1'b0;
    end else if (iq_pop) begin
      running_r <= running_nxt;
      active_r  <= active_nxt;
      step_r    <= step_nxt;
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      poll_r    <= poll_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      rhold_r   <= rhold_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

  // Capture the timeout limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: tick queue, sequencer and result queue.
//
//   channel  | ports                         | moves
//   ---------+-------------------------------+------------------------------
//   input    | push, full, in_item           | one third-bit tick request
//   result   | pop, empty, out_item          | pin levels and status per tick
//   config   | cfg_we, cfg_wdata             | ACK timeout limit
//
// One request per clock is sustained while the result queue has room; each request
// passes from the tick queue through the sequencer into the result queue.
// The sequencer is the single loop: it takes a queued request only when the
// result queue has room, so a stalled result side backs up into full.
// Reset (rst_n low, synchronous) empties both queues, idles the sequencer and
// releases SCL and SDA high; the timeout limit returns to 255.
`default_nettype none

module i2c_master_bit_engine #(
  parameter int unsigned IN_Q_DEPTH  = 2,
  parameter int unsigned OUT_Q_DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire i2cbe_pkg::in_item_t in_item,
  output logic                     full,
  input  wire logic                pop,
  output i2cbe_pkg::out_item_t     out_item,
  output logic                     empty,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);

  import i2cbe_pkg::*;

  cls_item_t iq_item;
  logic      iq_empty, iq_pop;
  logic      oq_full, oq_push;
  out_item_t oq_item;
  logic [$bits(out_item_t)-1:0] oq_rd;

  i2cbe_front #(
    .DEPTH (IN_Q_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .iq_pop   (iq_pop),
    .iq_item  (iq_item),
    .iq_empty (iq_empty)
  );

  i2cbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .iq_item   (iq_item),
    .iq_empty  (iq_empty),
    .iq_pop    (iq_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  i2cbe_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_item),
    .full    (oq_full),
    .pop     (pop),
    .rd_data (oq_rd),
    .empty   (empty)
  );

  assign out_item = out_item_t'(oq_rd);

  // Sequencer never advances into a full result queue
  a_no_pop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    iq_pop |-> !oq_full)
    else $error("sequencer consumed a request while result queue full");

  // Every consumed request yields exactly one result
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    iq_pop |-> oq_push)
    else $error("request consumed without a result");

  // A finishing tick is always a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_item.done_res) |-> oq_item.busy_res)
    else $error("done without busy");

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire
